@@ design/mssa_pkg.sv @@
package mssa_pkg;

  localparam int SLOT_W            = 6;
  localparam int STATUS_W          = 2;
  localparam int CFG_W             = 7;
  localparam int DEFAULT_MAX_SLOTS = 64;

  localparam logic [CFG_W-1:0] RESET_SLOT_COUNT = 7'd64;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL         = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FREE_RELEASE = 2'd2;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] slot;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   granted_slot;
    logic [STATUS_W-1:0] status;
  } rsp_t;

  // Sequencer commands to the gap unit.
  typedef struct packed {
    logic start;
    logic step;
    logic finish;
  } gap_ctrl_t;

  typedef struct packed {
    logic first_found;
    logic pick_valid;
  } gap_stat_t;

endpackage

@@ design/mssa_occ_mem.sv @@
module mssa_occ_mem #(
  parameter int DEPTH = mssa_pkg::DEFAULT_MAX_SLOTS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic                     wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic                     rdata
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/mssa_gap_unit.sv @@
module mssa_gap_unit #(
  parameter int MAX_SLOTS = mssa_pkg::DEFAULT_MAX_SLOTS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mssa_pkg::gap_ctrl_t          ctrl,
  input  logic [$clog2(MAX_SLOTS)-1:0] idx,
  input  logic [$clog2(MAX_SLOTS)-1:0] last,
  output mssa_pkg::gap_stat_t          stat,
  output logic [$clog2(MAX_SLOTS)-1:0] pick
);
  import mssa_pkg::*;

  localparam int AW = $clog2(MAX_SLOTS);

  logic          first_found;
  logic          pick_valid;
  logic [AW-1:0] prev;
  logic [AW-1:0] best;
  logic [AW-1:0] oper_a;
  logic [AW-1:0] diff;
  logic [AW-1:0] cand;
  logic          better;

  // One subtractor and one comparator serve both the interior gaps and the
  // trailing gap at the end of the scan.
  always_comb begin
    oper_a = ctrl.finish ? last : idx;
    diff   = oper_a - prev;
    cand   = ctrl.finish ? diff : (diff >> 1);
    better = cand > best;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_found <= 1'b0;
      pick_valid  <= 1'b0;
      best        <= '0;
    end else if (ctrl.start) begin
      first_found <= 1'b0;
      pick_valid  <= 1'b0;
      best        <= '0;
    end else if (ctrl.step) begin
      if (!first_found) begin
        first_found <= 1'b1;
        if (idx != '0) begin
          best       <= idx;
          pick       <= '0;
          pick_valid <= 1'b1;
        end
      end else if (better) begin
        best       <= cand;
        pick       <= prev + cand;
        pick_valid <= 1'b1;
      end
      prev <= idx;
    end else if (ctrl.finish) begin
      if (first_found && prev != last && better) begin
        pick       <= last;
        pick_valid <= 1'b1;
      end
    end
  end

  assign stat.first_found = first_found;
  assign stat.pick_valid  = pick_valid;

  a_pick_needs_first: assert property (@(posedge clk) disable iff (rst)
    pick_valid |-> first_found)
    else $error("gap unit holds a pick without any occupied slot");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    ctrl.start |=> (!first_found && !pick_valid))
    else $error("gap unit not cleared at scan start");

  a_step_marks_first: assert property (@(posedge clk) disable iff (rst)
    (ctrl.step && !ctrl.start) |=> first_found)
    else $error("occupied slot seen but first not recorded");

endmodule

@@ design/max_spacing_slot_allocator_top.sv @@
// Channel   Direction  Handshake            Beat
// in        input      in_valid / in_stall   req_t: kind, slot
// out       output     out_valid / out_stall rsp_t: granted_slot, status
// cfg       input      cfg_valid / cfg_ready slot_count write data
//
// An allocate reads the occupancy memory one slot per cycle through a single
// gap unit, then passes through S_FINISH and S_PICK before its result is sent.
// A release does one memory read, then the update; an out-of-range slot skips both.
// After reset a clearing pass zeroes all MAX_SLOTS words of the memory; in_stall
// stays high during it. The result register lets an item's result wait on
// out_stall while the next item is accepted.
module max_spacing_slot_allocator_top #(
  parameter int MAX_SLOTS = mssa_pkg::DEFAULT_MAX_SLOTS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  mssa_pkg::req_t               in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output mssa_pkg::rsp_t               out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mssa_pkg::CFG_W-1:0]   cfg_data
);
  import mssa_pkg::*;

  localparam int AW = $clog2(MAX_SLOTS);
  localparam int EW = (AW > CFG_W ? AW : CFG_W) + 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_PICK,
    S_REL_WAIT,
    S_RESULT
  } state_t;

  state_t                state;
  logic [CFG_W-1:0]      slot_count;
  logic [AW-1:0]         clr_cnt;
  logic [AW-1:0]         idx;
  logic [AW-1:0]         rel_addr;
  logic [SLOT_W-1:0]     res_slot;
  logic [STATUS_W-1:0]   res_status;

  logic [EW-1:0]         cnt_ext;
  logic [EW-1:0]         eff_cnt;
  logic [EW-1:0]         eff_m1;
  logic [AW-1:0]         last;
  logic [EW-1:0]         slot_ext;
  logic                  slot_in_range;
  logic [AW-1:0]         slot_addr;
  logic [EW-1:0]         pick_ext;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic                  mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic                  mem_rdata;

  gap_ctrl_t             gap_ctrl;
  gap_stat_t             gap_stat;
  logic [AW-1:0]         gap_pick;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // A count of zero behaves as one; counts above the store size are clamped.
  always_comb begin
    cnt_ext = EW'(slot_count);
    if (slot_count == '0) begin
      eff_cnt = EW'(1);
    end else if (cnt_ext > EW'(MAX_SLOTS)) begin
      eff_cnt = EW'(MAX_SLOTS);
    end else begin
      eff_cnt = cnt_ext;
    end
    eff_m1        = eff_cnt - EW'(1);
    last          = eff_m1[AW-1:0];
    slot_ext      = EW'(in_data.slot);
    slot_in_range = slot_ext < EW'(MAX_SLOTS);
    slot_addr     = slot_ext[AW-1:0];
    pick_ext      = EW'(gap_pick);
  end

  always_comb begin
    gap_ctrl.start  = (state == S_IDLE) && in_valid && (in_data.kind == KIND_ALLOC);
    gap_ctrl.step   = (state == S_SCAN) && mem_rdata;
    gap_ctrl.finish = (state == S_FINISH);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_cnt;
    mem_wdata = 1'b0;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_PICK: begin
        // An empty store gives slot 0; no pick at all means the store is full.
        if (!gap_stat.first_found) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = 1'b1;
        end else if (gap_stat.pick_valid) begin
          mem_we    = 1'b1;
          mem_waddr = gap_pick;
          mem_wdata = 1'b1;
        end
      end
      S_REL_WAIT: begin
        mem_we    = mem_rdata;
        mem_waddr = rel_addr;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (state)
      S_IDLE:  mem_raddr = (in_data.kind == KIND_RELEASE) ? slot_addr : '0;
      S_SCAN:  mem_raddr = idx + AW'(1);
      default: mem_raddr = idx;
    endcase
  end

  mssa_occ_mem #(
    .DEPTH (MAX_SLOTS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mssa_gap_unit #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_gap (
    .clk  (clk),
    .rst  (rst),
    .ctrl (gap_ctrl),
    .idx  (idx),
    .last (last),
    .stat (gap_stat),
    .pick (gap_pick)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      out_valid  <= 1'b0;
      slot_count <= RESET_SLOT_COUNT;
    end else begin
      if (cfg_valid && cfg_ready) begin
        slot_count <= cfg_data;
      end
      // In S_RESULT the case below decides out_valid on its own.
      if (out_valid && !out_stall && state != S_RESULT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(MAX_SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.kind == KIND_RELEASE) begin
              res_slot <= in_data.slot;
              rel_addr <= slot_addr;
              if (slot_in_range) begin
                state <= S_REL_WAIT;
              end else begin
                res_status <= ST_FREE_RELEASE;
                state      <= S_RESULT;
              end
            end else begin
              idx   <= '0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Read data for slot idx is on mem_rdata this cycle.
          if (idx == last) begin
            state <= S_FINISH;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        S_FINISH: begin
          state <= S_PICK;
        end
        S_PICK: begin
          if (!gap_stat.first_found) begin
            res_slot   <= '0;
            res_status <= ST_OK;
          end else if (gap_stat.pick_valid) begin
            res_slot   <= pick_ext[SLOT_W-1:0];
            res_status <= ST_OK;
          end else begin
            res_slot   <= '0;
            res_status <= ST_FULL;
          end
          state <= S_RESULT;
        end
        S_REL_WAIT: begin
          res_status <= mem_rdata ? ST_OK : ST_FREE_RELEASE;
          state      <= S_RESULT;
        end
        S_RESULT: begin
          if (!out_valid || !out_stall) begin
            out_data.granted_slot <= res_slot;
            out_data.status       <= res_status;
            out_valid             <= 1'b1;
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_clear_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> in_stall)
    else $error("input accepted during the clearing pass");

  a_scan_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_IDLE) |-> !mem_we)
    else $error("occupancy written outside an update step");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_FULL ||
                   out_data.status == ST_FREE_RELEASE))
    else $error("result carries an undefined status");

  a_full_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == ST_FULL) |-> (out_data.granted_slot == '0))
    else $error("full status with a nonzero slot");

endmodule

@@ verif/tb_max_spacing_slot_allocator_top.sv @@
`timescale 1ns / 1ps

module tb_max_spacing_slot_allocator_top;
  import mssa_pkg::*;

  localparam int NUM_SLOTS = DEFAULT_MAX_SLOTS;
  localparam int PHASE_ITEMS = 240;
  localparam int MAX_PRINTS = 40;

  // Tracks slot occupancy and the live count, and queues the expected grants.
  class occupancy_model;
    bit occ[NUM_SLOTS];
    logic [CFG_W-1:0] count_reg;
    rsp_t expected_grants[$];
    int mismatches;

    function new();
      foreach (occ[i]) occ[i] = 1'b0;
      count_reg = RESET_SLOT_COUNT;
      mismatches = 0;
    endfunction

    function void set_count(input logic [CFG_W-1:0] v);
      count_reg = v;
    endfunction

    function int live_count();
      if (count_reg < 1) return 1;
      if (count_reg > NUM_SLOTS) return NUM_SLOTS;
      return int'(count_reg);
    endfunction

    // Widest gap wins; ties keep the lowest slot. Returns -1 when full.
    function int widest_gap_slot();
      int cnt, first, prev, best, pick;
      cnt = live_count();
      first = -1;
      prev = -1;
      best = 0;
      pick = -1;
      for (int i = 0; i < cnt; i++) begin
        if (!occ[i]) continue;
        if (first < 0) begin
          first = i;
          if (i > 0) begin
            best = i;
            pick = 0;
          end
        end else if ((i - prev) / 2 > best) begin
          best = (i - prev) / 2;
          pick = prev + best;
        end
        prev = i;
      end
      if (first < 0) return 0;
      if (prev != cnt - 1 && (cnt - 1 - prev) > best) pick = cnt - 1;
      return pick;
    endfunction

    function void note_request(input req_t r);
      rsp_t e;
      int s;
      if (r.kind == KIND_ALLOC) begin
        s = widest_gap_slot();
        if (s < 0) begin
          e.granted_slot = '0;
          e.status = ST_FULL;
        end else begin
          occ[s] = 1'b1;
          e.granted_slot = SLOT_W'(s);
          e.status = ST_OK;
        end
      end else begin
        e.granted_slot = r.slot;
        if (occ[r.slot]) begin
          occ[r.slot] = 1'b0;
          e.status = ST_OK;
        end else begin
          e.status = ST_FREE_RELEASE;
        end
      end
      expected_grants.push_back(e);
    endfunction

    function int pending();
      return expected_grants.size();
    endfunction

    function int pick_occupied();
      int held[$];
      foreach (occ[i]) if (occ[i]) held.push_back(i);
      if (held.size() == 0) return -1;
      return held[$urandom_range(held.size() - 1)];
    endfunction

    task report_mismatch(input string msg);
      if (mismatches < MAX_PRINTS) $display("%0t: mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_grant(input rsp_t got);
      rsp_t e;
      if (expected_grants.size() == 0) begin
        report_mismatch($sformatf("unexpected result slot %0d status %0d",
                                  got.granted_slot, got.status));
      end else begin
        e = expected_grants.pop_front();
        if (got.granted_slot !== e.granted_slot)
          report_mismatch($sformatf("granted_slot got %0d want %0d",
                                    got.granted_slot, e.granted_slot));
        if (got.status !== e.status)
          report_mismatch($sformatf("status got %0d want %0d", got.status, e.status));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall;
  rsp_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  int send_idle_pct;
  int recv_stall_pct;
  int phase_counts[8] = '{64, 1, 127, 5, 0, 33, 2, 65};
  occupancy_model model = new();

  max_spacing_slot_allocator_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Requests are noted before results so a beat is always predicted first.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) model.note_request(in_data);
      if (out_valid && !out_stall) model.check_grant(out_data);
    end
  end

  task automatic send_req(input logic kind, input logic [SLOT_W-1:0] slot);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data.kind <= kind;
    in_data.slot <= slot;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (model.pending() != 0) @(negedge clk);
  endtask

  task automatic write_count(input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    model.set_count(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Alternates fill and empty stretches so the store regularly reaches full
  // and empty, with occasional releases of arbitrary slots as noise.
  task automatic run_phase(input logic [CFG_W-1:0] cnt, input int idle, input int stall);
    bit filling;
    int stretch;
    int roll;
    int s;
    logic kind;
    logic [SLOT_W-1:0] slot;
    drain();
    send_idle_pct = idle;
    recv_stall_pct = stall;
    write_count(cnt);
    filling = 1'b1;
    stretch = $urandom_range(20, 120);
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      if (stretch == 0) begin
        filling = !filling;
        stretch = $urandom_range(20, 120);
      end
      stretch--;
      if (k == PHASE_ITEMS / 2) drain();
      slot = SLOT_W'($urandom_range(NUM_SLOTS - 1));
      roll = $urandom_range(99);
      if (roll < (filling ? 85 : 20)) begin
        kind = KIND_ALLOC;
      end else begin
        kind = KIND_RELEASE;
        if (roll < 95) begin
          s = model.pick_occupied();
          if (s >= 0) slot = SLOT_W'(s);
        end
      end
      send_req(kind, slot);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset count: empty store, both ends, interior gaps, free and held releases.
    send_req(KIND_ALLOC, 6'd0);
    send_req(KIND_ALLOC, 6'd63);
    send_req(KIND_ALLOC, 6'd21);
    send_req(KIND_ALLOC, 6'd42);
    send_req(KIND_RELEASE, 6'd5);
    send_req(KIND_RELEASE, 6'd63);
    send_req(KIND_RELEASE, 6'd63);
    send_req(KIND_ALLOC, 6'd0);

    // One slot: full store, and a release above the count still clears.
    drain();
    write_count(7'd1);
    send_req(KIND_ALLOC, 6'd0);
    send_req(KIND_RELEASE, 6'd0);
    send_req(KIND_ALLOC, 6'd0);
    send_req(KIND_ALLOC, 6'd0);
    send_req(KIND_RELEASE, 6'd31);

    // A count of zero behaves as one.
    drain();
    write_count(7'd0);
    send_req(KIND_ALLOC, 6'd0);
    send_req(KIND_RELEASE, 6'd0);
    send_req(KIND_ALLOC, 6'd0);

    // Counts above the store size clamp; bits above a lowered count are kept.
    drain();
    write_count(7'd127);
    send_req(KIND_ALLOC, 6'd0);
    send_req(KIND_ALLOC, 6'd0);
    drain();
    write_count(7'd2);
    send_req(KIND_ALLOC, 6'd0);
    send_req(KIND_ALLOC, 6'd0);
    send_req(KIND_ALLOC, 6'd0);
    send_req(KIND_RELEASE, 6'd1);

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: run_phase(CFG_W'(p == 5 ? $urandom_range(3, 64) : phase_counts[p]), 0, 0);
        1: run_phase(CFG_W'(p == 5 ? $urandom_range(3, 64) : phase_counts[p]), 82, 0);
        2: run_phase(CFG_W'(p == 5 ? $urandom_range(3, 64) : phase_counts[p]), 0, 82);
        default: run_phase(CFG_W'(p == 5 ? $urandom_range(3, 64) : phase_counts[p]), 8, 8);
      endcase
    end

    drain();
    repeat (80) @(posedge clk);
    if (model.mismatches == 0) begin
      $display("max_spacing_slot_allocator_top test passed");
    end else begin
      $display("max_spacing_slot_allocator_top test failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("max_spacing_slot_allocator_top test failed");
    $finish;
  end

endmodule
